// ----- rtl/lcgrd_pkg.sv -----
// Shared types and constants for the LCG random range draw block.
`default_nettype none

package lcgrd_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned ValueW = 33;
    localparam int unsigned StepCntW = $clog2(WordW);

    localparam logic [WordW-1:0] LcgMul = 32'd214013;
    localparam logic [WordW-1:0] LcgAdd = 32'd2531011;
    localparam logic [WordW-1:0] MaxDraw = 32'hFFFF_FFFF;

    localparam logic [1:0] KIND_RAW = 2'd0;
    localparam logic [1:0] KIND_RANGE = 2'd1;
    localparam logic [1:0] KIND_SEED = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [WordW-1:0] range_low;
        logic signed [WordW-1:0] range_high;
        logic [WordW-1:0]        new_seed;
    } item_in_t;

    typedef struct packed {
        logic signed [ValueW-1:0] value;
        logic [WordW-1:0]         seed_now;
    } item_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPAN,
        ST_SCALE,
        ST_CLAMP,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/lcg_random_range_draw.sv -----
// Top level: LCG random source with range draws, one shared restoring divider.
// Raw draw, set seed, empty range and the none kind go straight to the result state;
// a non-empty range draw makes two 32-step passes of one bit-serial divider (span
// divisor, then scaled quotient), then a clamp state, then loads the output register.
// One item at a time: the input stalls until the result is loaded.
// Reset (rst_n low, asynchronous): seed 1, tick count 0, sequencer idle, output empty.
`default_nettype none

module lcg_random_range_draw (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire lcgrd_pkg::item_in_t in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output lcgrd_pkg::item_out_t     out_data
);

    localparam int unsigned W = lcgrd_pkg::WordW;
    localparam int unsigned CW = lcgrd_pkg::StepCntW;

    // Sequencer state
    lcgrd_pkg::state_t state_reg, state_next;

    // Architectural state
    logic [W-1:0] seed_reg, seed_next;
    logic [W-1:0] tick_reg, tick_next;

    // Shared divider: dividend shifts out at the top, quotient bits shift in at the bottom
    logic [W-1:0]  dvd_reg, dvd_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // Bounds held for the clamp
    logic signed [W-1:0] lo_reg, lo_next;
    logic signed [W-1:0] hi_reg, hi_next;

    // Result waiting for the output register, and the output register itself
    logic signed [lcgrd_pkg::ValueW-1:0] res_reg, res_next;
    logic                                out_valid_reg, out_valid_next;
    lcgrd_pkg::item_out_t                out_reg, out_next;

    logic          accept;
    logic          out_free;
    logic [W-1:0]  seed_adv;
    logic [W:0]    span;
    logic [W:0]    shifted;
    logic [W+1:0]  diff;
    logic          ge;
    logic          last_step;
    logic [W+1:0]  sum;
    logic [W+1:0]  hi_ext;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // One LCG step: 32x18 multiply, keep the low word
    assign seed_adv = W'(seed_reg * lcgrd_pkg::LcgMul + lcgrd_pkg::LcgAdd);

    // Span is hi - lo + 1, exact in 33 bits
    assign span = (W+1)'($signed({in_data.range_high[W-1], in_data.range_high})
                 - $signed({in_data.range_low[W-1], in_data.range_low}) + 1);

    // One restoring division step per cycle
    assign shifted   = {rem_reg, dvd_reg[W-1]};
    assign diff      = {1'b0, shifted} - {2'b00, dvs_reg};
    assign ge        = !diff[W+1];
    assign last_step = (cnt_reg == CW'(W - 1));

    // Clamp: lo + quotient against hi, both sign-extended to 34 bits
    assign sum    = {{2{lo_reg[W-1]}}, lo_reg} + {2'b00, dvd_reg};
    assign hi_ext = {{2{hi_reg[W-1]}}, hi_reg};

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lcgrd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.kind == lcgrd_pkg::KIND_RANGE
                        && in_data.range_high > in_data.range_low)
                    begin
                        state_next = lcgrd_pkg::ST_SPAN;
                    end
                    else
                    begin
                        state_next = lcgrd_pkg::ST_DONE;
                    end
                end
            end
            lcgrd_pkg::ST_SPAN:
            begin
                if (last_step)
                begin
                    state_next = lcgrd_pkg::ST_SCALE;
                end
            end
            lcgrd_pkg::ST_SCALE:
            begin
                if (last_step)
                begin
                    state_next = lcgrd_pkg::ST_CLAMP;
                end
            end
            lcgrd_pkg::ST_CLAMP:
            begin
                state_next = lcgrd_pkg::ST_DONE;
            end
            lcgrd_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = lcgrd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcgrd_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        in_stall  = (state_reg != lcgrd_pkg::ST_IDLE);
        out_valid = out_valid_reg;
        out_data  = out_reg;
    end

    // Datapath next values
    always_comb
    begin
        seed_next      = seed_reg;
        tick_next      = tick_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        cnt_next       = cnt_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        // Drop the output once it is taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            lcgrd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    tick_next = W'(tick_reg + 1'b1);
                    lo_next   = in_data.range_low;
                    hi_next   = in_data.range_high;
                    rem_next  = '0;
                    cnt_next  = '0;
                    dvd_next  = lcgrd_pkg::MaxDraw;
                    dvs_next  = span[W-1:0];
                    unique case (in_data.kind)
                        lcgrd_pkg::KIND_RAW:
                        begin
                            seed_next = seed_adv;
                            res_next  = $signed({1'b0, seed_adv});
                        end
                        lcgrd_pkg::KIND_RANGE:
                        begin
                            if (in_data.range_high > in_data.range_low)
                            begin
                                seed_next = seed_adv;
                                // A full 2^32 span divides by one: make the span pass yield 1
                                if (span[W])
                                begin
                                    dvs_next = lcgrd_pkg::MaxDraw;
                                end
                            end
                            res_next = $signed({in_data.range_low[W-1], in_data.range_low});
                        end
                        lcgrd_pkg::KIND_SEED:
                        begin
                            // Zero asks for the tick count before this transfer
                            if (in_data.new_seed == '0)
                            begin
                                seed_next = tick_reg;
                                res_next  = $signed({1'b0, tick_reg});
                            end
                            else
                            begin
                                seed_next = in_data.new_seed;
                                res_next  = $signed({1'b0, in_data.new_seed});
                            end
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            lcgrd_pkg::ST_SPAN:
            begin
                rem_next = ge ? diff[W-1:0] : shifted[W-1:0];
                dvd_next = {dvd_reg[W-2:0], ge};
                cnt_next = CW'(cnt_reg + 1'b1);
                // Reload: the quotient becomes the divisor, the seed the dividend
                if (last_step)
                begin
                    dvs_next = {dvd_reg[W-2:0], ge};
                    dvd_next = seed_reg;
                    rem_next = '0;
                    cnt_next = '0;
                end
            end
            lcgrd_pkg::ST_SCALE:
            begin
                rem_next = ge ? diff[W-1:0] : shifted[W-1:0];
                dvd_next = {dvd_reg[W-2:0], ge};
                cnt_next = CW'(cnt_reg + 1'b1);
            end
            lcgrd_pkg::ST_CLAMP:
            begin
                if ($signed(sum) > $signed(hi_ext))
                begin
                    res_next = $signed({hi_reg[W-1], hi_reg});
                end
                else
                begin
                    res_next = $signed(sum[W:0]);
                end
            end
            lcgrd_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_next.value    = res_reg;
                    out_next.seed_now = seed_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcgrd_pkg::ST_IDLE;
            seed_reg      <= W'(1);
            tick_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            tick_reg      <= tick_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    // The divider never runs with a zero divisor: span is at least two, its quotient at least one
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lcgrd_pkg::ST_SPAN || state_reg == lcgrd_pkg::ST_SCALE)
        |-> (dvs_reg != '0))
        else $error("divider running with zero divisor");

    // The clamp follows only the final step of the scaling pass
    a_clamp_after_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lcgrd_pkg::ST_CLAMP)
        |-> ($past(state_reg) == lcgrd_pkg::ST_SCALE && $past(cnt_reg) == CW'(W - 1)))
        else $error("clamp entered before the division finished");

    // A new result appears only when the sequencer hands one over
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == lcgrd_pkg::ST_DONE))
        else $error("output loaded outside the result state");

endmodule

`default_nettype wire
